### rtl/fxh_pkg.sv
package fxh_pkg;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned BIN_IDX_W = 7;
   localparam int unsigned OUT_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned BIN_CNT_W = 8;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_LOW = 2'd0,
      CSR_BIN_SCALE = 2'd1,
      CSR_BIN_COUNT = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_idx_type;

   localparam logic signed [SAMPLE_W-1:0] RANGE_LOW_RST = -32'sd327680;
   localparam logic [SAMPLE_W-1:0] BIN_SCALE_RST = 32'd655360;
   localparam logic [BIN_CNT_W-1:0] BIN_COUNT_RST = 8'd100;

   typedef struct packed {
      op_type                      op;
      logic signed [SAMPLE_W-1:0]  sample_value;
      logic [BIN_IDX_W-1:0]        bin_index;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] bin_value;
      logic [OUT_W-1:0] total_added;
      logic             in_range;
   } rsp_type;

endpackage

### rtl/fxh_ram.sv
module fxh_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fixed_range_histogram.sv
// Channel   Dir  Handshake             Payload
// req_      in   req_valid/req_stall   req_data   (fxh_pkg::req_type)
// rsp_      out  rsp_valid/rsp_stall   rsp_data   (fxh_pkg::rsp_type)
// csr_      in   csr_we                csr_index, csr_wdata
//
// One word at a time. Add runs from accept to result register through difference,
// multiply, bin compare and RAM read, write back and output; read runs through RAM
// read and output; clear through a clearing pass and output. The RAM sets these steps.
// After reset a clearing pass writes zero to all MAX_BINS bins, one per cycle,
// with req_stall high. A held result in the output register does not block the next
// accept; only the hand-over into that register waits for rsp_stall to drop.
module fixed_range_histogram #(
   parameter int unsigned MAX_BINS = 128,
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fxh_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fxh_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [fxh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fxh_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned IDX_W = $clog2(MAX_BINS);
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(MAX_BINS - 1);
   localparam logic [31:0] MAX_BINS_32 = 32'(MAX_BINS);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_IDX   = 7'b0001000,
      S_RMW   = 7'b0010000,
      S_READ  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   function automatic logic [fxh_pkg::OUT_W-1:0] clip32(input logic [63:0] v);
      clip32 = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // control state
   state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic clr_item_ff, clr_item_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic signed [fxh_pkg::SAMPLE_W-1:0] range_low_ff, range_low_in;
   logic [fxh_pkg::SAMPLE_W-1:0] bin_scale_ff, bin_scale_in;
   logic [fxh_pkg::BIN_CNT_W-1:0] bin_count_ff, bin_count_in;

   // payload
   logic signed [fxh_pkg::SAMPLE_W:0] diff_ff, diff_in;
   logic [31:0] idx_ff, idx_in;
   logic hit_ff, hit_in;
   logic rd_ok_ff, rd_ok_in;
   fxh_pkg::rsp_type res_ff, res_in;
   fxh_pkg::rsp_type rsp_ff, rsp_in;

   logic accept;
   logic out_load;
   logic [63:0] product;
   logic [31:0] used;
   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [COUNT_WIDTH-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [COUNT_WIDTH-1:0] ram_rdata;
   logic [COUNT_WIDTH-1:0] total_inc;

   fxh_ram #(
      .WIDTH(COUNT_WIDTH),
      .DEPTH(MAX_BINS)
   ) u_bins (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign accept = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign product = 64'(diff_ff[31:0]) * 64'(bin_scale_ff);
   assign used = (32'(bin_count_ff) > MAX_BINS_32) ? MAX_BINS_32 : 32'(bin_count_ff);
   assign total_inc = (total_ff == '1) ? total_ff : total_ff + 1'b1;
   assign ram_raddr = (state_ff == S_IDX) ? idx_ff[IDX_W-1:0]
                                          : IDX_W'(req_data.bin_index);

   always_comb begin
      state_in = state_ff;
      clr_ptr_in = clr_ptr_ff;
      clr_item_in = clr_item_ff;
      total_in = total_ff;
      diff_in = diff_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      rd_ok_in = rd_ok_ff;
      res_in = res_ff;
      ram_we = 1'b0;
      ram_waddr = clr_ptr_ff;
      ram_wdata = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == LAST_BIN) begin
               clr_ptr_in = '0;
               if (clr_item_ff) begin
                  res_in = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (accept) begin
               diff_in = (fxh_pkg::SAMPLE_W + 1)'(req_data.sample_value)
                         - (fxh_pkg::SAMPLE_W + 1)'(range_low_ff);
               rd_ok_in = (32'(req_data.bin_index) < MAX_BINS_32);
               unique case (req_data.op)
                  fxh_pkg::OP_ADD: begin
                     state_in = S_MUL;
                  end
                  fxh_pkg::OP_READ: begin
                     state_in = S_READ;
                  end
                  fxh_pkg::OP_CLEAR: begin
                     total_in = '0;
                     clr_item_in = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     res_in.bin_value = '0;
                     res_in.total_added = clip32(64'(total_ff));
                     res_in.in_range = 1'b0;
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_MUL: begin
            idx_in = product[63:32];
            state_in = S_IDX;
         end
         S_IDX: begin
            // negative difference is below the low edge
            hit_in = !diff_ff[fxh_pkg::SAMPLE_W] && (idx_ff < used);
            state_in = S_RMW;
         end
         S_RMW: begin
            ram_we = hit_ff;
            ram_waddr = idx_ff[IDX_W-1:0];
            ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
            total_in = total_inc;
            res_in.bin_value = '0;
            res_in.total_added = clip32(64'(total_inc));
            res_in.in_range = hit_ff;
            state_in = S_OUT;
         end
         S_READ: begin
            res_in.bin_value = rd_ok_ff ? clip32(64'(ram_rdata)) : '0;
            res_in.total_added = clip32(64'(total_ff));
            res_in.in_range = 1'b0;
            state_in = S_OUT;
         end
         S_OUT: begin
            clr_item_in = 1'b0;
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: hold while stalled
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_in = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      range_low_in = range_low_ff;
      bin_scale_in = bin_scale_ff;
      bin_count_in = bin_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            fxh_pkg::CSR_RANGE_LOW: range_low_in = csr_wdata;
            fxh_pkg::CSR_BIN_SCALE: bin_scale_in = csr_wdata;
            fxh_pkg::CSR_BIN_COUNT: bin_count_in = csr_wdata[fxh_pkg::BIN_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ptr_ff <= '0;
         clr_item_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff <= '0;
         range_low_ff <= fxh_pkg::RANGE_LOW_RST;
         bin_scale_ff <= fxh_pkg::BIN_SCALE_RST;
         bin_count_ff <= fxh_pkg::BIN_COUNT_RST;
      end else begin
         state_ff <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         clr_item_ff <= clr_item_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff <= total_in;
         range_low_ff <= range_low_in;
         bin_scale_ff <= bin_scale_in;
         bin_count_ff <= bin_count_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      rd_ok_ff <= rd_ok_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
